// ===== rtl/core/rdmc_pkg.sv =====
package rdmc_pkg;

    localparam int TimerBitsDefault = 16;
    localparam int QueueDepth       = 2;
    localparam int CfgWidth         = 16;

    localparam logic [CfgWidth-1:0] MaxRunReset   = 16'd25000;
    localparam logic [CfgWidth-1:0] PauseReset    = 16'd500;

    // Configuration register indexes.
    localparam logic CFG_MAX_RUN = 1'b0;
    localparam logic CFG_PAUSE   = 1'b1;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_CLOSE = 2'd2,
        CMD_LIMIT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_OPEN  = 2'd1,
        MODE_CLOSE = 2'd2,
        MODE_PAUSE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OPEN    = 2'd0,
        ST_CLOSED  = 2'd1,
        ST_UNKNOWN = 2'd2
    } t_status;

    // Classified item handed from the front to the back.
    typedef struct packed {
        t_cmd    cmd;
        t_status status;
    } t_item;

    // Result as it waits in the output queue.
    typedef struct packed {
        t_mode   mode;
        logic    report;
        t_status status;
    } t_result;

    // Configuration write bundle.
    typedef struct packed {
        logic                we;
        logic                idx;
        logic [CfgWidth-1:0] data;
    } t_cfg;

endpackage

// ===== rtl/core/reversing_door_motor_controller.sv =====
// An item transferred into the item queue is taken by the back end once the result queue has room;
// its result is registered in the result queue before it appears on the result ports.
// Throughput: one item per cycle while the item queue holds an item and the result queue has room.
// Two-entry queues before and after the back end absorb stalls on either side.
// Reset (synchronous, active low) empties both queues, sets the mode to idle, clears the
// timers and pending direction, marks the status unknown and loads the default limits.
module reversing_door_motor_controller #(
    parameter int TIMER_BITS = rdmc_pkg::TimerBitsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_command,
    input  logic                          i_limit_a,
    input  logic                          i_limit_b,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_drive_open,
    output logic                          o_drive_close,
    output logic [1:0]                    o_motor_mode,
    output logic                          o_report_valid,
    output logic [1:0]                    o_door_status,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [rdmc_pkg::CfgWidth-1:0] i_cfg_data
);

    localparam int ItemW = $bits(rdmc_pkg::t_item);
    localparam int ResW  = $bits(rdmc_pkg::t_result);

    rdmc_pkg::t_item   w_front_item, w_back_item;
    rdmc_pkg::t_result w_res, w_head;
    rdmc_pkg::t_cfg    w_cfg;
    logic              w_front_wr;
    logic              w_item_empty;
    logic              w_res_full;
    logic              w_step;
    logic [ItemW-1:0]  w_item_bits;
    logic [ResW-1:0]   w_head_bits;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    rdmc_front u_front (
        .i_push    (push),
        .i_full    (full),
        .i_command (i_command),
        .i_limit_a (i_limit_a),
        .i_limit_b (i_limit_b),
        .o_wr      (w_front_wr),
        .o_item    (w_front_item)
    );

    rdmc_fifo #(
        .DEPTH (rdmc_pkg::QueueDepth),
        .WIDTH (ItemW)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_wr),
        .i_data  (w_front_item),
        .o_full  (full),
        .i_pop   (w_step),
        .o_data  (w_item_bits),
        .o_empty (w_item_empty)
    );

    assign w_back_item = rdmc_pkg::t_item'(w_item_bits);

    rdmc_back #(
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item       (w_back_item),
        .i_item_empty (w_item_empty),
        .i_res_full   (w_res_full),
        .o_step       (w_step),
        .o_res        (w_res)
    );

    rdmc_fifo #(
        .DEPTH (rdmc_pkg::QueueDepth),
        .WIDTH (ResW)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_step),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_head_bits),
        .o_empty (empty)
    );

    assign w_head         = rdmc_pkg::t_result'(w_head_bits);
    assign o_drive_open   = (w_head.mode == rdmc_pkg::MODE_OPEN);
    assign o_drive_close  = (w_head.mode == rdmc_pkg::MODE_CLOSE);
    assign o_motor_mode   = w_head.mode;
    assign o_report_valid = w_head.report;
    assign o_door_status  = w_head.status;

`ifndef SYNTH
    // The back end only stalls on a full result queue, so a full item queue means results wait.
    a_full_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("item queue full while no result is waiting");

    // A processed item must be visible as a result at the next edge.
    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> !empty)
        else $error("processed item did not produce a result");

    // An item transferred into an empty pipeline reaches the result side through the item queue and the back end.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && w_item_empty && empty) |=> ##1 !empty)
        else $error("result latency exceeded two cycles");
`endif

endmodule

// ===== rtl/core/rdmc_fifo.sv =====
module rdmc_fifo #(
    parameter int DEPTH = rdmc_pkg::QueueDepth,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == CntFull);
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + CntW'(1);
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/rdmc_front.sv =====
module rdmc_front (
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic [1:0]           i_command,
    input  logic                 i_limit_a,
    input  logic                 i_limit_b,
    output logic                 o_wr,
    output rdmc_pkg::t_item      o_item
);

    rdmc_pkg::t_status w_status;

    // Detector A alone is closed, detector B alone is open, anything else unknown.
    always_comb begin
        unique case ({i_limit_b, i_limit_a})
            2'b01:   w_status = rdmc_pkg::ST_CLOSED;
            2'b10:   w_status = rdmc_pkg::ST_OPEN;
            default: w_status = rdmc_pkg::ST_UNKNOWN;
        endcase
    end

    assign o_wr          = i_push && !i_full;
    assign o_item.cmd    = rdmc_pkg::t_cmd'(i_command);
    assign o_item.status = w_status;

endmodule

// ===== rtl/core/rdmc_back.sv =====
module rdmc_back #(
    parameter int TIMER_BITS = rdmc_pkg::TimerBitsDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rdmc_pkg::t_cfg       i_cfg,
    input  rdmc_pkg::t_item      i_item,
    input  logic                 i_item_empty,
    input  logic                 i_res_full,
    output logic                 o_step,
    output rdmc_pkg::t_result    o_res
);

    logic [rdmc_pkg::CfgWidth-1:0] r_max_run, r_pause_cfg;
    rdmc_pkg::t_mode               r_mode, n_mode;
    logic [TIMER_BITS-1:0]         r_run, n_run;
    logic [TIMER_BITS-1:0]         r_pause, n_pause;
    logic                          r_pend, n_pend;
    rdmc_pkg::t_status             r_last, n_last;
    logic                          w_report;
    logic [TIMER_BITS-1:0]         w_run_load, w_pause_load, w_pause_dec;
    logic                          w_dir_close;
    rdmc_pkg::t_mode               w_dir_mode, w_opposite;
    rdmc_pkg::t_status             w_target;

    assign o_step = !i_item_empty && !i_res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_run   <= rdmc_pkg::MaxRunReset;
            r_pause_cfg <= rdmc_pkg::PauseReset;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                rdmc_pkg::CFG_MAX_RUN: r_max_run   <= i_cfg.data;
                rdmc_pkg::CFG_PAUSE:   r_pause_cfg <= i_cfg.data;
                default:               r_max_run   <= r_max_run;
            endcase
        end
    end

    // A run limit of zero counts as one tick.
    always_comb begin
        w_run_load   = TIMER_BITS'(r_max_run);
        if (w_run_load == '0) begin
            w_run_load = TIMER_BITS'(1);
        end
        w_pause_load = TIMER_BITS'(r_pause_cfg);
        w_pause_dec  = (r_pause != '0) ? r_pause - TIMER_BITS'(1) : '0;
        w_dir_close  = (i_item.cmd == rdmc_pkg::CMD_CLOSE);
        w_dir_mode   = w_dir_close ? rdmc_pkg::MODE_CLOSE : rdmc_pkg::MODE_OPEN;
        w_opposite   = w_dir_close ? rdmc_pkg::MODE_OPEN : rdmc_pkg::MODE_CLOSE;
        w_target     = w_dir_close ? rdmc_pkg::ST_CLOSED : rdmc_pkg::ST_OPEN;
    end

    always_comb begin
        n_mode   = r_mode;
        n_run    = r_run;
        n_pause  = r_pause;
        n_pend   = r_pend;
        n_last   = r_last;
        w_report = 1'b0;
        unique case (i_item.cmd)
            rdmc_pkg::CMD_TICK: begin
                if (r_mode == rdmc_pkg::MODE_PAUSE) begin
                    n_pause = w_pause_dec;
                    if (w_pause_dec == '0) begin
                        n_run  = w_run_load;
                        n_mode = r_pend ? rdmc_pkg::MODE_CLOSE : rdmc_pkg::MODE_OPEN;
                    end
                end else if (r_run != '0) begin
                    n_run = r_run - TIMER_BITS'(1);
                    // Expiry stops the motor silently; only the status is refreshed.
                    if (r_run == TIMER_BITS'(1)) begin
                        n_last = i_item.status;
                        n_mode = rdmc_pkg::MODE_IDLE;
                    end
                end
            end
            rdmc_pkg::CMD_OPEN, rdmc_pkg::CMD_CLOSE: begin
                n_last = i_item.status;
                if (i_item.status == w_target) begin
                    w_report = 1'b1;
                end else if (r_mode == rdmc_pkg::MODE_PAUSE) begin
                    n_pend = w_dir_close;
                end else if (r_mode == w_opposite) begin
                    n_run   = '0;
                    n_pend  = w_dir_close;
                    n_pause = w_pause_load;
                    if (w_pause_load == '0) begin
                        n_run  = w_run_load;
                        n_mode = w_dir_mode;
                    end else begin
                        n_mode = rdmc_pkg::MODE_PAUSE;
                    end
                end else begin
                    n_run  = w_run_load;
                    n_mode = w_dir_mode;
                end
            end
            rdmc_pkg::CMD_LIMIT: begin
                n_last = i_item.status;
                if ((r_mode == rdmc_pkg::MODE_CLOSE && i_item.status == rdmc_pkg::ST_CLOSED) ||
                    (r_mode == rdmc_pkg::MODE_OPEN && i_item.status == rdmc_pkg::ST_OPEN)) begin
                    n_mode   = rdmc_pkg::MODE_IDLE;
                    w_report = 1'b1;
                end else if (!(r_mode == rdmc_pkg::MODE_IDLE &&
                               i_item.status == rdmc_pkg::ST_UNKNOWN)) begin
                    w_report = 1'b1;
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= rdmc_pkg::MODE_IDLE;
            r_run   <= '0;
            r_pause <= '0;
            r_pend  <= 1'b0;
            r_last  <= rdmc_pkg::ST_UNKNOWN;
        end else if (o_step) begin
            r_mode  <= n_mode;
            r_run   <= n_run;
            r_pause <= n_pause;
            r_pend  <= n_pend;
            r_last  <= n_last;
        end
    end

    assign o_res.mode   = n_mode;
    assign o_res.report = w_report;
    assign o_res.status = n_last;

endmodule
